// ===== rtl/core/ipcl_pkg.sv =====
// Shared types, codes and helpers for the IPv6 prefix client table.
package ipcl_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int ADDR_W                = 128;
   localparam int HALF_W                = 64;
   localparam int PLEN_W                = 8;
   localparam int COST_W                = 8;
   localparam int HIT_W                 = 4;
   localparam logic [PLEN_W-1:0] FULL_PREFIX = 8'd128;

   typedef enum logic [2:0] {
      CMD_ADD    = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_EXACT  = 3'd2,
      CMD_LOOKUP = 3'd3,
      CMD_CLEAR  = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EXISTS  = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE    = 1'b0,
      S_RESOLVE = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   function automatic logic [PLEN_W-1:0] clamp_plen(input logic [PLEN_W-1:0] p);
      clamp_plen = (p > FULL_PREFIX) ? FULL_PREFIX : p;
   endfunction

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] p);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      if (p >= FULL_PREFIX) begin
         prefix_mask = ones;
      end else if (p == '0) begin
         prefix_mask = '0;
      end else begin
         prefix_mask = ones << (FULL_PREFIX - p);
      end
   endfunction

endpackage

// ===== rtl/core/ipcl_ctrl.sv =====
// Controller state machine: handshakes and datapath commands.
module ipcl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ipcl_pkg::ctrl_cmd_type cmd
);

   ipcl_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipcl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ipcl_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ipcl_pkg::S_RESOLVE;
            end
         end
         ipcl_pkg::S_RESOLVE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = ipcl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ipcl_pkg::S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/ipcl_datapath.sv =====
// Datapath: slot storage, parallel slot compare, selection and result register.
module ipcl_datapath #(
   parameter int TABLE_ENTRIES = ipcl_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ipcl_pkg::ctrl_cmd_type        cmd,
   input  logic [2:0]                    req_command,
   input  logic [ipcl_pkg::HALF_W-1:0]   req_addr_hi,
   input  logic [ipcl_pkg::HALF_W-1:0]   req_addr_lo,
   input  logic [ipcl_pkg::PLEN_W-1:0]   req_prefix_len,
   input  logic [ipcl_pkg::COST_W-1:0]   req_cost,
   output logic [1:0]                    rsp_status,
   output logic [ipcl_pkg::HIT_W-1:0]    rsp_hit_index,
   output logic [ipcl_pkg::PLEN_W-1:0]   rsp_found_prefix_len,
   output logic [ipcl_pkg::COST_W-1:0]   rsp_found_cost,
   output logic [ipcl_pkg::HALF_W-1:0]   rsp_found_addr_hi,
   output logic [ipcl_pkg::HALF_W-1:0]   rsp_found_addr_lo
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int AW    = ipcl_pkg::ADDR_W;
   localparam int HW    = ipcl_pkg::HALF_W;
   localparam int PW    = ipcl_pkg::PLEN_W;
   localparam int CW    = ipcl_pkg::COST_W;
   localparam int HITW  = ipcl_pkg::HIT_W;

   function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      first_set = idx;
   endfunction

   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [AW-1:0]            slot_addr_ff [TABLE_ENTRIES];
   logic [PW-1:0]            slot_plen_ff [TABLE_ENTRIES];
   logic [CW-1:0]            slot_cost_ff [TABLE_ENTRIES];

   logic [2:0]               command_ff;
   logic [AW-1:0]            addr_ff;
   logic [PW-1:0]            plen_ff;
   logic [CW-1:0]            cost_ff;
   logic [TABLE_ENTRIES-1:0] exact_hits_ff, exact_hits_in;
   logic [TABLE_ENTRIES-1:0] cover_hits_ff, cover_hits_in;

   logic [1:0]               status_ff, status_in;
   logic [HITW-1:0]          hit_index_ff, hit_index_in;
   logic [PW-1:0]            found_plen_ff, found_plen_in;
   logic [CW-1:0]            found_cost_ff, found_cost_in;
   logic [AW-1:0]            found_addr_ff, found_addr_in;

   logic [AW-1:0]            req_addr;
   logic [PW-1:0]            req_plen;
   logic [IDX_W-1:0]         sel_idx;
   logic [IDX_W+HITW-1:0]    sel_wide;
   logic                     src_slot, src_new, wr_en, del_en, clr_en;
   ipcl_pkg::status_type     status_sel;

   assign req_addr = {req_addr_hi, req_addr_lo};
   assign req_plen = ipcl_pkg::clamp_plen(req_prefix_len);

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         logic covers;
         covers = ((slot_addr_ff[i] ^ req_addr) &
                   ipcl_pkg::prefix_mask(slot_plen_ff[i])) == '0;
         cover_hits_in[i] = slot_valid_ff[i] & covers;
         exact_hits_in[i] = slot_valid_ff[i] & covers & (slot_plen_ff[i] == req_plen);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff    <= req_command;
         addr_ff       <= req_addr & ipcl_pkg::prefix_mask(req_plen);
         plen_ff       <= req_plen;
         cost_ff       <= req_cost;
         exact_hits_ff <= exact_hits_in;
         cover_hits_ff <= cover_hits_in;
      end
   end

   always_comb begin
      sel_idx    = '0;
      status_sel = ipcl_pkg::STATUS_MISSING;
      src_slot   = 1'b0;
      src_new    = 1'b0;
      wr_en      = 1'b0;
      del_en     = 1'b0;
      clr_en     = 1'b0;
      case (command_ff)
         ipcl_pkg::CMD_ADD: begin
            if (|exact_hits_ff) begin
               status_sel = ipcl_pkg::STATUS_EXISTS;
               sel_idx    = first_set(exact_hits_ff);
               src_slot   = 1'b1;
            end else if (|(~slot_valid_ff)) begin
               status_sel = ipcl_pkg::STATUS_OK;
               sel_idx    = first_set(~slot_valid_ff);
               src_new    = 1'b1;
               wr_en      = 1'b1;
            end else begin
               status_sel = ipcl_pkg::STATUS_FULL;
            end
         end
         ipcl_pkg::CMD_DELETE: begin
            if (|exact_hits_ff) begin
               status_sel = ipcl_pkg::STATUS_OK;
               sel_idx    = first_set(exact_hits_ff);
               src_slot   = 1'b1;
               del_en     = 1'b1;
            end
         end
         ipcl_pkg::CMD_EXACT: begin
            if (|exact_hits_ff) begin
               status_sel = ipcl_pkg::STATUS_OK;
               sel_idx    = first_set(exact_hits_ff);
               src_slot   = 1'b1;
            end
         end
         ipcl_pkg::CMD_LOOKUP: begin
            if (|cover_hits_ff) begin
               status_sel = ipcl_pkg::STATUS_OK;
               sel_idx    = first_set(cover_hits_ff);
               src_slot   = 1'b1;
            end
         end
         ipcl_pkg::CMD_CLEAR: begin
            status_sel = ipcl_pkg::STATUS_OK;
            clr_en     = 1'b1;
         end
         default: begin
            status_sel = ipcl_pkg::STATUS_MISSING;
         end
      endcase
   end

   assign sel_wide = {{HITW{1'b0}}, sel_idx};

   always_comb begin
      status_in     = status_sel;
      hit_index_in  = '0;
      found_plen_in = '0;
      found_cost_in = '0;
      found_addr_in = '0;
      if (src_slot) begin
         hit_index_in  = sel_wide[HITW-1:0];
         found_plen_in = slot_plen_ff[sel_idx];
         found_cost_in = slot_cost_ff[sel_idx];
         found_addr_in = slot_addr_ff[sel_idx];
      end else if (src_new) begin
         hit_index_in  = sel_wide[HITW-1:0];
         found_plen_in = plen_ff;
         found_cost_in = cost_ff;
         found_addr_in = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff     <= status_in;
         hit_index_ff  <= hit_index_in;
         found_plen_ff <= found_plen_in;
         found_cost_ff <= found_cost_in;
         found_addr_ff <= found_addr_in;
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (cmd.commit) begin
         if (clr_en) begin
            slot_valid_in = '0;
         end else if (wr_en) begin
            slot_valid_in[sel_idx] = 1'b1;
         end else if (del_en) begin
            slot_valid_in[sel_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         slot_addr_ff[sel_idx] <= addr_ff;
         slot_plen_ff[sel_idx] <= plen_ff;
         slot_cost_ff[sel_idx] <= cost_ff;
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_hit_index        = hit_index_ff;
   assign rsp_found_prefix_len = found_plen_ff;
   assign rsp_found_cost       = found_cost_ff;
   assign rsp_found_addr_hi    = found_addr_ff[AW-1:HW];
   assign rsp_found_addr_lo    = found_addr_ff[HW-1:0];

endmodule

// ===== rtl/core/ipv6_prefix_client_table_unit.sv =====
// Top level of the IPv6 prefix client table: controller plus datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  command, addr_hi, addr_lo, prefix_len, cost
//   rsp      out        rsp_valid/rsp_stall  status, hit_index, found_prefix_len,
//                                            found_cost, found_addr_hi, found_addr_lo
//
// Each transfer does a slot compare into registered hit vectors at the accept
// edge, then select, table write and result register load in the resolve state.
// One transfer is in flight at a time; the next is taken while a result waits.
// A stalled result holds the resolve state until the result register frees.
// Reset empties the table at once (slot valid bits only).
module ipv6_prefix_client_table_unit #(
   parameter int TABLE_ENTRIES = ipcl_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_command,
   input  logic [ipcl_pkg::HALF_W-1:0]   req_addr_hi,
   input  logic [ipcl_pkg::HALF_W-1:0]   req_addr_lo,
   input  logic [ipcl_pkg::PLEN_W-1:0]   req_prefix_len,
   input  logic [ipcl_pkg::COST_W-1:0]   req_cost,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [ipcl_pkg::HIT_W-1:0]    rsp_hit_index,
   output logic [ipcl_pkg::PLEN_W-1:0]   rsp_found_prefix_len,
   output logic [ipcl_pkg::COST_W-1:0]   rsp_found_cost,
   output logic [ipcl_pkg::HALF_W-1:0]   rsp_found_addr_hi,
   output logic [ipcl_pkg::HALF_W-1:0]   rsp_found_addr_lo
);

   ipcl_pkg::ctrl_cmd_type cmd;

   ipcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ipcl_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_command          (req_command),
      .req_addr_hi          (req_addr_hi),
      .req_addr_lo          (req_addr_lo),
      .req_prefix_len       (req_prefix_len),
      .req_cost             (req_cost),
      .rsp_status           (rsp_status),
      .rsp_hit_index        (rsp_hit_index),
      .rsp_found_prefix_len (rsp_found_prefix_len),
      .rsp_found_cost       (rsp_found_cost),
      .rsp_found_addr_hi    (rsp_found_addr_hi),
      .rsp_found_addr_lo    (rsp_found_addr_lo)
   );

endmodule

// ===== sim/tb_ipv6_prefix_client_table_unit.sv =====
// Self-checking testbench: random and directed prefix-table requests against a slot predictor.
module tb_ipv6_prefix_client_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W       = ipcl_pkg::ADDR_W;
   localparam int HALF_W       = ipcl_pkg::HALF_W;
   localparam int PLEN_W       = ipcl_pkg::PLEN_W;
   localparam int COST_W       = ipcl_pkg::COST_W;
   localparam int HIT_W        = ipcl_pkg::HIT_W;
   localparam logic [PLEN_W-1:0] FULL_PREFIX = ipcl_pkg::FULL_PREFIX;
   localparam int CLK_HALF     = 5;
   localparam int SLOTS        = ipcl_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int POOL         = 20;
   localparam int ROUNDS       = 7;
   localparam int MIXED        = 80;
   localparam int SETTLE       = 8;
   localparam int LIMIT_CYCLES = 200000;
   localparam int MAX_WAIT     = 16;
   localparam logic [2:0] CMD_RESERVED_LO = 3'(ipcl_pkg::CMD_CLEAR) + 3'd1;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [HALF_W-1:0] addr_hi;
      logic [HALF_W-1:0] addr_lo;
      logic [PLEN_W-1:0] plen;
      logic [COST_W-1:0] cost;
   } prefix_req_type;

   typedef struct packed {
      ipcl_pkg::status_type status;
      logic [HIT_W-1:0]     hit;
      logic [PLEN_W-1:0]    plen;
      logic [COST_W-1:0]    cost;
      logic [HALF_W-1:0]    addr_hi;
      logic [HALF_W-1:0]    addr_lo;
   } prefix_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_command = '0;
   logic [HALF_W-1:0] req_addr_hi = '0;
   logic [HALF_W-1:0] req_addr_lo = '0;
   logic [PLEN_W-1:0] req_prefix_len = '0;
   logic [COST_W-1:0] req_cost = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [HIT_W-1:0]  rsp_hit_index;
   logic [PLEN_W-1:0] rsp_found_prefix_len;
   logic [COST_W-1:0] rsp_found_cost;
   logic [HALF_W-1:0] rsp_found_addr_hi;
   logic [HALF_W-1:0] rsp_found_addr_lo;

   prefix_req_type req_backlog[$];
   prefix_rsp_type due_results[$];

   logic              slot_used [SLOTS];
   logic [ADDR_W-1:0] slot_addr [SLOTS];
   logic [PLEN_W-1:0] slot_plen [SLOTS];
   logic [COST_W-1:0] slot_cost [SLOTS];

   logic [ADDR_W-1:0] pool_addr [POOL];
   logic [PLEN_W-1:0] pool_plen [POOL];

   int  cycles = 0;
   int  mismatches = 0;
   int  sent = 0;
   int  checked = 0;
   int  status_tally [4] = '{0, 0, 0, 0};
   int  req_wait = 0;
   bit  req_calm = 1'b0;
   int  rsp_hold = 0;
   bit  rsp_calm = 1'b0;

   ipv6_prefix_client_table_unit #(
      .TABLE_ENTRIES(SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_addr_hi(req_addr_hi),
      .req_addr_lo(req_addr_lo),
      .req_prefix_len(req_prefix_len),
      .req_cost(req_cost),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_hit_index(rsp_hit_index),
      .rsp_found_prefix_len(rsp_found_prefix_len),
      .rsp_found_cost(rsp_found_cost),
      .rsp_found_addr_hi(rsp_found_addr_hi),
      .rsp_found_addr_lo(rsp_found_addr_lo)
   );

   always #CLK_HALF clock = ~clock;

   function automatic logic [ADDR_W-1:0] span_mask(input logic [PLEN_W-1:0] p);
      logic [ADDR_W-1:0] m;
      m = '1;
      if (p == '0) begin
         return '0;
      end
      return m << (ADDR_W - p);
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [ADDR_W-1:0] scramble_below(input logic [ADDR_W-1:0] a,
                                                        input logic [PLEN_W-1:0] p);
      return (a & span_mask(p)) | (rand_addr() & ~span_mask(p));
   endfunction

   function automatic int slot_search(input logic [ADDR_W-1:0] a, input logic [PLEN_W-1:0] p,
                                      input bit exact);
      int s;
      for (s = 0; s < SLOTS; s++) begin
         if (slot_used[s] && (!exact || slot_plen[s] == p) &&
             ((slot_addr[s] ^ a) & span_mask(slot_plen[s])) == '0) begin
            return s;
         end
      end
      return -1;
   endfunction

   function automatic prefix_rsp_type slot_describe(input ipcl_pkg::status_type st,
                                                    input int s);
      prefix_rsp_type r;
      r.status  = st;
      r.hit     = s[HIT_W-1:0];
      r.plen    = slot_plen[s];
      r.cost    = slot_cost[s];
      r.addr_hi = slot_addr[s][ADDR_W-1:HALF_W];
      r.addr_lo = slot_addr[s][HALF_W-1:0];
      return r;
   endfunction

   function automatic void slot_wipe(input int s);
      slot_used[s] = 1'b0;
      slot_addr[s] = '0;
      slot_plen[s] = '0;
      slot_cost[s] = '0;
   endfunction

   function automatic void table_apply(input prefix_req_type rq);
      logic [PLEN_W-1:0] p;
      logic [ADDR_W-1:0] a;
      int                s;
      int                free;
      prefix_rsp_type    r;
      p = (rq.plen > FULL_PREFIX) ? FULL_PREFIX : rq.plen;
      a = {rq.addr_hi, rq.addr_lo};
      r = '0;
      r.status = ipcl_pkg::STATUS_MISSING;
      case (rq.cmd)
         ipcl_pkg::CMD_ADD: begin
            s = slot_search(a, p, 1'b1);
            if (s >= 0) begin
               r = slot_describe(ipcl_pkg::STATUS_EXISTS, s);
            end else begin
               free = -1;
               for (s = 0; s < SLOTS; s++) begin
                  if (!slot_used[s]) begin
                     free = s;
                     break;
                  end
               end
               if (free < 0) begin
                  r.status = ipcl_pkg::STATUS_FULL;
               end else begin
                  slot_used[free] = 1'b1;
                  slot_addr[free] = a & span_mask(p);
                  slot_plen[free] = p;
                  slot_cost[free] = rq.cost;
                  r = slot_describe(ipcl_pkg::STATUS_OK, free);
               end
            end
         end
         ipcl_pkg::CMD_DELETE: begin
            s = slot_search(a, p, 1'b1);
            if (s >= 0) begin
               r = slot_describe(ipcl_pkg::STATUS_OK, s);
               slot_wipe(s);
            end
         end
         ipcl_pkg::CMD_EXACT: begin
            s = slot_search(a, p, 1'b1);
            if (s >= 0) begin
               r = slot_describe(ipcl_pkg::STATUS_OK, s);
            end
         end
         ipcl_pkg::CMD_LOOKUP: begin
            s = slot_search(a, p, 1'b0);
            if (s >= 0) begin
               r = slot_describe(ipcl_pkg::STATUS_OK, s);
            end
         end
         ipcl_pkg::CMD_CLEAR: begin
            for (s = 0; s < SLOTS; s++) begin
               slot_wipe(s);
            end
            r.status = ipcl_pkg::STATUS_OK;
         end
         default: begin
         end
      endcase
      due_results.push_back(r);
   endfunction

   task automatic note_mismatch(input string what, input logic [HALF_W-1:0] got,
                                input logic [HALF_W-1:0] want);
      mismatches++;
      if (mismatches <= 50) begin
         $display("%0t: %s at result %0d: got %h, want %h", $realtime, what, checked, got, want);
      end
   endtask

   task automatic queue_req(input logic [2:0] cmd, input logic [ADDR_W-1:0] a,
                            input logic [PLEN_W-1:0] p, input logic [COST_W-1:0] c);
      prefix_req_type rq;
      rq.cmd     = cmd;
      rq.addr_hi = a[ADDR_W-1:HALF_W];
      rq.addr_lo = a[HALF_W-1:0];
      rq.plen    = p;
      rq.cost    = c;
      req_backlog.push_back(rq);
   endtask

   function automatic logic [PLEN_W-1:0] wire_plen(input logic [PLEN_W-1:0] p);
      if (p == FULL_PREFIX && $urandom_range(0, 2) == 0) begin
         return PLEN_W'($urandom_range(129, 255));
      end
      return p;
   endfunction

   task automatic build_pool();
      logic [ADDR_W-1:0] root;
      int                len;
      int                k;
      for (k = 0; k < POOL; k++) begin
         if (k % 4 == 0) begin
            root = rand_addr();
            len  = $urandom_range(0, 20);
         end else begin
            len = len + $urandom_range(0, 44);
            if (len > 128) begin
               len = 128;
            end
         end
         pool_addr[k] = scramble_below(root, PLEN_W'(len));
         pool_plen[k] = PLEN_W'(len);
      end
   endtask

   task automatic queue_mixed();
      int                k;
      int                roll;
      logic [ADDR_W-1:0] a;
      logic [PLEN_W-1:0] p;
      k    = $urandom_range(0, POOL - 1);
      a    = scramble_below(pool_addr[k], pool_plen[k]);
      p    = wire_plen(pool_plen[k]);
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         queue_req(ipcl_pkg::CMD_ADD, a, p, COST_W'($urandom));
      end else if (roll < 45) begin
         queue_req(ipcl_pkg::CMD_DELETE, a, p, COST_W'($urandom));
      end else if (roll < 60) begin
         queue_req(ipcl_pkg::CMD_EXACT, a, p, COST_W'($urandom));
      end else if (roll < 85) begin
         queue_req(ipcl_pkg::CMD_LOOKUP, a, PLEN_W'($urandom), COST_W'($urandom));
      end else if (roll < 86) begin
         queue_req(ipcl_pkg::CMD_CLEAR, rand_addr(), PLEN_W'($urandom), COST_W'($urandom));
      end else if (roll < 91) begin
         queue_req(CMD_RESERVED_LO + 3'($urandom_range(0, 2)), a, p, COST_W'($urandom));
      end else begin
         queue_req(3'($urandom_range(0, 4)), rand_addr(), PLEN_W'($urandom),
                   COST_W'($urandom));
      end
   endtask

   task automatic queue_round();
      int order [POOL];
      int k;
      int j;
      int t;
      build_pool();
      for (k = 0; k < POOL; k++) begin
         order[k] = k;
      end
      for (k = POOL - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         t        = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      queue_req(ipcl_pkg::CMD_CLEAR, '0, '0, '0);
      for (k = 0; k < SLOTS + 3; k++) begin
         queue_req(ipcl_pkg::CMD_ADD, pool_addr[order[k]], wire_plen(pool_plen[order[k]]),
                   COST_W'($urandom));
      end
      for (k = 0; k < MIXED; k++) begin
         queue_mixed();
      end
   endtask

   task automatic queue_directed();
      logic [ADDR_W-1:0] ones;
      logic [ADDR_W-1:0] a;
      ones = '1;
      a    = rand_addr();
      queue_req(ipcl_pkg::CMD_LOOKUP, ones, 8'd0, 8'd0);
      queue_req(ipcl_pkg::CMD_DELETE, ones, FULL_PREFIX, 8'hff);
      queue_req(ipcl_pkg::CMD_ADD, '0, 8'd0, 8'd0);
      queue_req(ipcl_pkg::CMD_LOOKUP, a, 8'd77, 8'd1);
      queue_req(ipcl_pkg::CMD_ADD, ones, 8'd255, 8'hff);
      queue_req(ipcl_pkg::CMD_EXACT, ones, FULL_PREFIX, 8'd0);
      queue_req(ipcl_pkg::CMD_ADD, ones, 8'd200, 8'd3);
      queue_req(ipcl_pkg::CMD_ADD, {a[ADDR_W-1:HALF_W], {HALF_W{1'b1}}}, 8'd64, 8'h5a);
      queue_req(ipcl_pkg::CMD_ADD, ones, 8'd65, 8'ha5);
      queue_req(ipcl_pkg::CMD_ADD, ones, 8'd1, 8'd9);
      queue_req(ipcl_pkg::CMD_ADD, a, 8'd127, 8'd127);
      queue_req(ipcl_pkg::CMD_EXACT, a, 8'd126, 8'd0);
      queue_req(ipcl_pkg::CMD_LOOKUP, ones, 8'd0, 8'd0);
      queue_req(CMD_RESERVED_LO, ones, 8'd1, 8'd1);
      queue_req(CMD_RESERVED_LO + 3'd1, a, 8'd129, 8'd2);
      queue_req(CMD_RESERVED_LO + 3'd2, '0, 8'd0, 8'd0);
      queue_req(ipcl_pkg::CMD_DELETE, a, 8'd0, 8'd0);
      queue_req(ipcl_pkg::CMD_LOOKUP, a, 8'd0, 8'd0);
      queue_req(ipcl_pkg::CMD_DELETE, ones, 8'd129, 8'd0);
      queue_req(ipcl_pkg::CMD_LOOKUP, ones, 8'd0, 8'd0);
   endtask

   always @(posedge clock) begin
      prefix_req_type rq;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait  <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            rq.cmd     = req_command;
            rq.addr_hi = req_addr_hi;
            rq.addr_lo = req_addr_lo;
            rq.plen    = req_prefix_len;
            rq.cost    = req_cost;
            table_apply(rq);
            sent++;
         end
         if (req_wait == 0 && req_backlog.size() > 0) begin
            rq = req_backlog.pop_front();
            req_valid      <= 1'b1;
            req_command    <= rq.cmd;
            req_addr_hi    <= rq.addr_hi;
            req_addr_lo    <= rq.addr_lo;
            req_prefix_len <= rq.plen;
            req_cost       <= rq.cost;
            if ($urandom_range(0, 39) == 0) begin
               req_calm = !req_calm;
            end
            req_wait <= req_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end else begin
            req_valid <= 1'b0;
            if (req_wait != 0) begin
               req_wait <= req_wait - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      prefix_rsp_type w;
      int             n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         n = rsp_hold;
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               note_mismatch("result with nothing due", HALF_W'(rsp_status), '0);
            end else begin
               w = due_results.pop_front();
               if (rsp_status !== w.status) begin
                  note_mismatch("status", HALF_W'(rsp_status), HALF_W'(w.status));
               end
               if (rsp_hit_index !== w.hit) begin
                  note_mismatch("hit_index", HALF_W'(rsp_hit_index), HALF_W'(w.hit));
               end
               if (rsp_found_prefix_len !== w.plen) begin
                  note_mismatch("found_prefix_len", HALF_W'(rsp_found_prefix_len),
                                HALF_W'(w.plen));
               end
               if (rsp_found_cost !== w.cost) begin
                  note_mismatch("found_cost", HALF_W'(rsp_found_cost), HALF_W'(w.cost));
               end
               if (rsp_found_addr_hi !== w.addr_hi) begin
                  note_mismatch("found_addr_hi", rsp_found_addr_hi, w.addr_hi);
               end
               if (rsp_found_addr_lo !== w.addr_lo) begin
                  note_mismatch("found_addr_lo", rsp_found_addr_lo, w.addr_lo);
               end
               status_tally[w.status]++;
            end
            checked++;
            if ($urandom_range(0, 39) == 0) begin
               rsp_calm = !rsp_calm;
            end
            n = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= n - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  due_results.size());
         $display("FAIL ipv6_prefix_client_table_unit");
         $finish;
      end
   end

   initial begin
      int r;
      for (r = 0; r < SLOTS; r++) begin
         slot_wipe(r);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      for (r = 0; r < ROUNDS; r++) begin
         queue_round();
      end
      while (req_backlog.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
      $display("%0d requests sent, %0d results checked in %0d cycles", sent, checked, cycles);
      $display("statuses seen: ok %0d, duplicate %0d, table full %0d, not found %0d",
               status_tally[ipcl_pkg::STATUS_OK], status_tally[ipcl_pkg::STATUS_EXISTS],
               status_tally[ipcl_pkg::STATUS_FULL], status_tally[ipcl_pkg::STATUS_MISSING]);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("PASS ipv6_prefix_client_table_unit");
      end else begin
         $display("FAIL ipv6_prefix_client_table_unit");
      end
      $finish;
   end

endmodule
